@@ hdl/olads_pkg.sv @@
// Shared constants and codes for the ordered value list.
package olads_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 6;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [VAL_W-1:0]  word_t;

endpackage

@@ hdl/olads_req_if.sv @@
// Request channel: operation mode and value, valid/ready handshake.
interface olads_req_if;
  logic                              valid;
  logic                              ready;
  logic [olads_pkg::MODE_W-1:0]      mode;
  logic signed [olads_pkg::VAL_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

@@ hdl/olads_rsp_if.sv @@
// Response channel: status and position, valid/ready handshake.
interface olads_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [olads_pkg::STAT_W-1:0]  status;
  logic [olads_pkg::POS_W-1:0]   position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

@@ hdl/ordered_list_append_delete_search.sv @@
// Ordered value list with append, delete-first-match and search-first-match.
//
// Channels: req carries mode and value, rsp carries status and position; an item
// moves on a beat where valid and ready are both high. Every request beat yields
// exactly one response beat, in order.
// One item is worked on at a time; the entries live in a single memory with one
// read and one write port whose read data is registered; the work per mode:
//   append / unused mode : no scan; the result goes straight to the finish step
//   search               : entries read in order, one entry compared per cycle
//   delete               : scan to the match, then one entry moved down per cycle
// A new request is taken once the previous item is finished, even while its
// response still sits in the output register. If the receiver stalls with a
// response held, the next finished result waits inside the block and req.ready stays
// low until the output register frees.
// Reset (rst, synchronous) empties the list and drops any pending response;
// memory contents are not cleared, only the first count entries are ever read.
module ordered_list_append_delete_search (
  input  logic               clk,
  input  logic               rst,
  olads_req_if.sink          req,
  olads_rsp_if.source        rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;

  olads_pkg::word_t mem [olads_pkg::CAPACITY];

  logic [2:0]                    state;
  olads_pkg::cnt_t               count;
  olads_pkg::cnt_t               issue_idx;
  olads_pkg::cnt_t               rd_idx;
  logic                          rd_vld;
  olads_pkg::word_t              rdata;
  logic [olads_pkg::MODE_W-1:0]  op_mode;
  olads_pkg::word_t              op_value;
  logic [olads_pkg::STAT_W-1:0]  res_status;
  logic [olads_pkg::POS_W-1:0]   res_pos;
  logic                          out_valid;
  logic [olads_pkg::STAT_W-1:0]  out_status;
  logic [olads_pkg::POS_W-1:0]   out_pos;

  logic              accept;
  logic              full;
  logic              issue;
  logic              match;
  logic              scan_end;
  logic              out_free;
  logic              mem_we;
  olads_pkg::addr_t  mem_waddr;
  olads_pkg::word_t  mem_wdata;
  olads_pkg::cnt_t   shift_dst;

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign full         = (count == olads_pkg::cnt_t'(olads_pkg::CAPACITY));
  assign issue        = ((state == S_SCAN) || (state == S_SHIFT)) && (issue_idx < count);
  assign match        = rd_vld && (rdata == op_value);
  assign scan_end     = (issue_idx >= count) && !rd_vld;
  assign out_free     = !out_valid || rsp.ready;
  assign shift_dst    = rd_idx - olads_pkg::cnt_t'(1);

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_pos;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[olads_pkg::ADDR_W-1:0];
    mem_wdata = req.value;
    if (accept && (req.mode == olads_pkg::MODE_APPEND) && !full) begin
      mem_we = 1'b1;
    end else if ((state == S_SHIFT) && rd_vld) begin
      mem_we    = 1'b1;
      mem_waddr = shift_dst[olads_pkg::ADDR_W-1:0];
      mem_wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata <= mem[issue_idx[olads_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issue_idx <= '0;
      rd_idx    <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_mode    <= req.mode;
            op_value   <= req.value;
            res_status <= olads_pkg::ST_OK;
            res_pos    <= '0;
            issue_idx  <= '0;
            rd_vld     <= 1'b0;
            if ((req.mode == olads_pkg::MODE_DELETE) ||
                (req.mode == olads_pkg::MODE_SEARCH)) begin
              state <= S_SCAN;
            end else begin
              if (req.mode == olads_pkg::MODE_APPEND) begin
                if (full) begin
                  res_status <= olads_pkg::ST_FULL;
                end else begin
                  count <= count + olads_pkg::cnt_t'(1);
                end
              end
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            rd_vld <= 1'b0;
            if (op_mode == olads_pkg::MODE_DELETE) begin
              issue_idx <= rd_idx + olads_pkg::cnt_t'(1);
              state     <= S_SHIFT;
            end else begin
              res_pos <= olads_pkg::POS_W'(rd_idx);
              state   <= S_FINISH;
            end
          end else if (scan_end) begin
            res_status <= olads_pkg::ST_NOT_FOUND;
            state      <= S_FINISH;
          end else begin
            rd_vld    <= issue;
            rd_idx    <= issue_idx;
            if (issue) begin
              issue_idx <= issue_idx + olads_pkg::cnt_t'(1);
            end
          end
        end
        S_SHIFT: begin
          if (scan_end) begin
            count <= count - olads_pkg::cnt_t'(1);
            state <= S_FINISH;
          end else begin
            rd_vld <= issue;
            rd_idx <= issue_idx;
            if (issue) begin
              issue_idx <= issue_idx + olads_pkg::cnt_t'(1);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_pos    <= res_pos;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= olads_pkg::cnt_t'(olads_pkg::CAPACITY))
    else $error("list count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("block idle right after taking a request");

  a_shift_dst: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) && rd_vld) |-> ((rd_idx != '0) && (rd_idx < count)))
    else $error("shift writes outside the list");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != olads_pkg::ST_OK)) |-> (out_pos == '0))
    else $error("nonzero position on a failed item");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_status) && $stable(out_pos)))
    else $error("stalled response changed");

endmodule
